@@ design/frm_pkg.sv @@
// Shared types and constants for the firewall rule table.
// No dependencies; used by frm_front, frm_back and firewall_rule_match.
`default_nettype none

package frm_pkg;

    localparam int RULES_DEFAULT = 64;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = 2;
    localparam int QCNT_W        = 3;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_CHECK = 1'b1
    } op_t;

    // One classified command beat. For a check, port_a and ip_a carry the
    // packet's port and address; port_b and ip_b are unused.
    typedef struct packed {
        op_t         op;
        logic        dir;
        logic        proto;
        logic [15:0] port_a;
        logic [15:0] port_b;
        logic [31:0] ip_a;
        logic [31:0] ip_b;
    } item_t;

endpackage

`default_nettype wire

@@ design/frm_front.sv @@
// Front end: accepts input beats, classifies them into item_t and holds
// them in a short queue for the back end. Depends on frm_pkg.
`default_nettype none

module frm_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic                command,
    input  wire logic                direction,
    input  wire logic                protocol,
    input  wire logic [15:0]         rule_port_low,
    input  wire logic [15:0]         rule_port_high,
    input  wire logic [31:0]         rule_ip_low,
    input  wire logic [31:0]         rule_ip_high,
    input  wire logic [15:0]         packet_port,
    input  wire logic [31:0]         packet_ip,
    output logic                     q_valid,
    output frm_pkg::item_t           q_item,
    input  wire logic                q_pop
);

    frm_pkg::item_t                      queue_mem [frm_pkg::QDEPTH];
    frm_pkg::item_t                      in_item;
    logic [frm_pkg::QPTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [frm_pkg::QPTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [frm_pkg::QCNT_W-1:0]          count_reg, count_next;
    logic                                do_push;
    logic                                do_pop;

    always_comb
    begin
        in_item.op     = frm_pkg::op_t'(command);
        in_item.dir    = direction;
        in_item.proto  = protocol;
        in_item.port_b = rule_port_high;
        in_item.ip_b   = rule_ip_high;
        if (frm_pkg::op_t'(command) == frm_pkg::OP_CHECK)
        begin
            in_item.port_a = packet_port;
            in_item.ip_a   = packet_ip;
        end
        else
        begin
            in_item.port_a = rule_port_low;
            in_item.ip_a   = rule_ip_low;
        end
    end

    assign full    = (count_reg == frm_pkg::QCNT_W'(frm_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = queue_mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

@@ design/frm_back.sv @@
// Back end: rule memory, fill count, rule scan and the result register.
// Takes classified items from frm_front. Depends on frm_pkg.
`default_nettype none

module frm_back #(
    parameter int RULES = frm_pkg::RULES_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire frm_pkg::item_t  q_item,
    output logic                 q_pop,
    output logic                 empty,
    input  wire logic            pop,
    output logic                 accepted,
    output logic                 table_full
);

    localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int CNT_W = $clog2(RULES + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic                 rvalid_reg, rvalid_next;
    logic                 rlast_reg, rlast_next;
    logic                 res_valid_reg, res_valid_next;
    logic                 res_acc_reg, res_acc_next;
    logic                 res_full_reg, res_full_next;

    logic [33:0]          class_mem [RULES];
    logic [63:0]          addr_mem [RULES];
    logic [33:0]          class_rd_reg;
    logic [63:0]          addr_rd_reg;
    frm_pkg::item_t       cur_reg;
    logic                 load_cur;
    logic                 mem_we;
    logic                 rd_en;
    logic                 hit;
    logic [CNT_W-1:0]     scan_inc;

    assign empty      = !res_valid_reg;
    assign accepted   = res_acc_reg;
    assign table_full = res_full_reg;
    assign scan_inc   = scan_reg + 1'b1;

    // Compare the rule read last cycle against the packet being checked.
    always_comb
    begin
        hit = rvalid_reg
              && (class_rd_reg[33] == cur_reg.dir)
              && (class_rd_reg[32] == cur_reg.proto)
              && (cur_reg.port_a >= class_rd_reg[31:16])
              && (cur_reg.port_a <= class_rd_reg[15:0])
              && (cur_reg.ip_a >= addr_rd_reg[31:0])
              && (cur_reg.ip_a <= addr_rd_reg[63:32]);
    end

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        scan_next      = scan_reg;
        rvalid_next    = 1'b0;
        rlast_next     = 1'b0;
        res_valid_next = res_valid_reg;
        res_acc_next   = res_acc_reg;
        res_full_next  = res_full_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        load_cur       = 1'b0;

        if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !res_valid_reg)
                begin
                    q_pop = 1'b1;
                    if (q_item.op == frm_pkg::OP_ADD)
                    begin
                        res_valid_next = 1'b1;
                        res_acc_next   = 1'b0;
                        if (used_reg == CNT_W'(RULES))
                        begin
                            res_full_next = 1'b1;
                        end
                        else
                        begin
                            res_full_next = 1'b0;
                            mem_we        = 1'b1;
                            used_next     = used_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        load_cur  = 1'b1;
                        scan_next = '0;
                        if (used_reg == '0)
                        begin
                            res_valid_next = 1'b1;
                            res_acc_next   = 1'b0;
                            res_full_next  = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue one rule read per cycle; compare it in the next cycle.
                rd_en = (scan_reg != used_reg);
                if (rd_en)
                begin
                    scan_next   = scan_inc;
                    rvalid_next = 1'b1;
                    rlast_next  = (scan_inc == used_reg);
                end
                if (hit || (rvalid_reg && rlast_reg))
                begin
                    // Drop any read still in flight.
                    rvalid_next    = 1'b0;
                    rlast_next     = 1'b0;
                    res_valid_next = 1'b1;
                    res_acc_next   = hit;
                    res_full_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            scan_reg      <= '0;
            rvalid_reg    <= 1'b0;
            rlast_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            res_acc_reg   <= 1'b0;
            res_full_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            scan_reg      <= scan_next;
            rvalid_reg    <= rvalid_next;
            rlast_reg     <= rlast_next;
            res_valid_reg <= res_valid_next;
            res_acc_reg   <= res_acc_next;
            res_full_reg  <= res_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            class_mem[used_reg[IDX_W-1:0]] <= {q_item.dir, q_item.proto,
                                               q_item.port_a, q_item.port_b};
            addr_mem[used_reg[IDX_W-1:0]]  <= {q_item.ip_b, q_item.ip_a};
        end
        if (rd_en)
        begin
            class_rd_reg <= class_mem[scan_reg[IDX_W-1:0]];
            addr_rd_reg  <= addr_mem[scan_reg[IDX_W-1:0]];
        end
        if (load_cur)
        begin
            cur_reg <= q_item;
        end
    end

endmodule

`default_nettype wire

@@ design/firewall_rule_match.sv @@
// Firewall rule table. An add, or a check with no rules stored, is answered directly from the
// queued beat; a check with N rules stored scans them in order and ends at the first rule that
// hits, or after rule N: the scan reads one rule per cycle from the rule memory's single read
// port. The back end takes the next queued beat once the result is popped, so it works on one
// add or check at a time.
// Reset clears the fill count, 4-beat queue and result register; no clearing pass.
`default_nettype none

module firewall_rule_match #(
    parameter int RULES = frm_pkg::RULES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        command,
    input  wire logic        direction,
    input  wire logic        protocol,
    input  wire logic [15:0] rule_port_low,
    input  wire logic [15:0] rule_port_high,
    input  wire logic [31:0] rule_ip_low,
    input  wire logic [31:0] rule_ip_high,
    input  wire logic [15:0] packet_port,
    input  wire logic [31:0] packet_ip,
    output logic             empty,
    input  wire logic        pop,
    output logic             accepted,
    output logic             table_full
);

    logic              q_valid;
    logic              q_pop;
    frm_pkg::item_t    q_item;

    frm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .command        (command),
        .direction      (direction),
        .protocol       (protocol),
        .rule_port_low  (rule_port_low),
        .rule_port_high (rule_port_high),
        .rule_ip_low    (rule_ip_low),
        .rule_ip_high   (rule_ip_high),
        .packet_port    (packet_port),
        .packet_ip      (packet_ip),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    frm_back #(
        .RULES (RULES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .accepted   (accepted),
        .table_full (table_full)
    );

endmodule

`default_nettype wire

@@ tb/firewall_rule_match_test.sv @@
// Self-checking testbench for firewall_rule_match: directed rule and packet beats,
// then random traffic checked against an in-bench rule table model.
// Depends on frm_pkg and the firewall_rule_match RTL only.
`timescale 1ns / 100ps

module firewall_rule_match_test;

    import frm_pkg::*;

    localparam int RULES       = RULES_DEFAULT;
    localparam int RANDOM_BEATS = 700;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = RULES + 8;

    typedef struct packed {
        op_t         op;
        logic        dir;
        logic        proto;
        logic [15:0] port_lo;
        logic [15:0] port_hi;
        logic [31:0] ip_lo;
        logic [31:0] ip_hi;
        logic [15:0] pkt_port;
        logic [31:0] pkt_ip;
    } rule_beat_t;

    typedef struct packed {
        logic accepted;
        logic table_full;
    } verdict_t;

    typedef struct packed {
        rule_beat_t beat;
        logic       typed;
        verdict_t   want;
    } stim_row_t;

    localparam int N_DIRECTED = 24;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        command;
    logic        direction;
    logic        protocol;
    logic [15:0] rule_port_low;
    logic [15:0] rule_port_high;
    logic [31:0] rule_ip_low;
    logic [31:0] rule_ip_high;
    logic [15:0] packet_port;
    logic [31:0] packet_ip;
    logic        empty;
    logic        pop;
    logic        accepted;
    logic        table_full;

    firewall_rule_match #(.RULES(RULES)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .command        (command),
        .direction      (direction),
        .protocol       (protocol),
        .rule_port_low  (rule_port_low),
        .rule_port_high (rule_port_high),
        .rule_ip_low    (rule_ip_low),
        .rule_ip_high   (rule_ip_high),
        .packet_port    (packet_port),
        .packet_ip      (packet_ip),
        .empty          (empty),
        .pop            (pop),
        .accepted       (accepted),
        .table_full     (table_full)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Rule table as the block should hold it
    logic        stored_dir     [RULES];
    logic        stored_proto   [RULES];
    logic [15:0] stored_port_lo [RULES];
    logic [15:0] stored_port_hi [RULES];
    logic [31:0] stored_ip_lo   [RULES];
    logic [31:0] stored_ip_hi   [RULES];
    int unsigned rules_stored = 0;

    verdict_t expected_verdicts[$];
    int       error_count = 0;
    int       results_seen = 0;
    int       hold_left = 0;
    bit       long_hold_done = 1'b0;
    bit       steady_run = 1'b0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        // empty table matches nothing
        '{'{OP_CHECK, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 16'd80, 32'h0A000001},
          1'b1, '{1'b0, 1'b0}},
        '{'{OP_ADD, 1'b0, 1'b0, 16'd80, 16'd80, 32'h0A000001, 32'h0A000001, 16'd0, 32'd0},
          1'b1, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 16'd80, 32'h0A000001},
          1'b0, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 16'd81, 32'h0A000001},
          1'b0, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b0, 1'b1, 16'd0, 16'd0, 32'd0, 32'd0, 16'd80, 32'h0A000001},
          1'b0, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b1, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 16'd80, 32'h0A000001},
          1'b0, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 16'd80, 32'h0A000002},
          1'b0, '{1'b0, 1'b0}},
        // full port and address span
        '{'{OP_ADD, 1'b1, 1'b1, 16'h0000, 16'hFFFF, 32'h0, 32'hFFFFFFFF, 16'd0, 32'd0},
          1'b1, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b1, 1'b1, 16'd0, 16'd0, 32'd0, 32'd0, 16'h0000, 32'h00000000},
          1'b0, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b1, 1'b1, 16'd0, 16'd0, 32'd0, 32'd0, 16'hFFFF, 32'hFFFFFFFF},
          1'b0, '{1'b0, 1'b0}},
        // inverted port range
        '{'{OP_ADD, 1'b0, 1'b1, 16'd200, 16'd100, 32'h0, 32'hFFFFFFFF, 16'd0, 32'd0},
          1'b1, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b0, 1'b1, 16'd0, 16'd0, 32'd0, 32'd0, 16'd150, 32'h12345678},
          1'b0, '{1'b0, 1'b0}},
        // inverted address range
        '{'{OP_ADD, 1'b1, 1'b0, 16'd1, 16'hFFFF, 32'd5, 32'd4, 16'd0, 32'd0},
          1'b1, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b1, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 16'd1000, 32'd4},
          1'b0, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b1, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 16'd1000, 32'd5},
          1'b0, '{1'b0, 1'b0}},
        // port zero in rule and packet, address edges of a /16
        '{'{OP_ADD, 1'b0, 1'b0, 16'd0, 16'd0, 32'hC0A80000, 32'hC0A8FFFF, 16'd0, 32'd0},
          1'b1, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 32'hC0A80000},
          1'b0, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 32'hC0A8FFFF},
          1'b0, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 32'hC0A7FFFF},
          1'b0, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 32'hC0A90000},
          1'b0, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 16'd1, 32'hC0A80000},
          1'b0, '{1'b0, 1'b0}},
        // top of both ranges
        '{'{OP_ADD, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd0, 32'd0},
          1'b1, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b1, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 16'hFFFF, 32'hFFFFFFFF},
          1'b0, '{1'b0, 1'b0}},
        '{'{OP_CHECK, 1'b1, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 16'hFFFE, 32'hFFFFFFFF},
          1'b0, '{1'b0, 1'b0}}
    };

    // Apply one accepted beat to the rule table and return its verdict
    function automatic verdict_t classify_beat(input rule_beat_t b);
        verdict_t v;
        v = '{1'b0, 1'b0};
        if (b.op == OP_ADD)
        begin
            if (rules_stored >= RULES)
                v.table_full = 1'b1;
            else
            begin
                stored_dir[rules_stored]     = b.dir;
                stored_proto[rules_stored]   = b.proto;
                stored_port_lo[rules_stored] = b.port_lo;
                stored_port_hi[rules_stored] = b.port_hi;
                stored_ip_lo[rules_stored]   = b.ip_lo;
                stored_ip_hi[rules_stored]   = b.ip_hi;
                rules_stored++;
            end
        end
        else
        begin
            for (int i = 0; i < rules_stored; i++)
            begin
                if (stored_dir[i] == b.dir && stored_proto[i] == b.proto &&
                    b.pkt_port >= stored_port_lo[i] && b.pkt_port <= stored_port_hi[i] &&
                    b.pkt_ip >= stored_ip_lo[i] && b.pkt_ip <= stored_ip_hi[i])
                    v.accepted = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic void gen_range(input logic [31:0] mask,
                                      output logic [31:0] lo, output logic [31:0] hi);
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom & mask;
        b = $urandom & mask;
        case ($urandom_range(0, 9))
            0, 1:    begin lo = a; hi = a; end
            2, 3, 4: begin lo = a; hi = (a + $urandom_range(0, 300)) & mask; end
            5:       begin lo = '0; hi = mask; end
            6:       begin lo = '0; hi = a; end
            7, 8:    begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
            // inverted (unless a equals b): stored but never matches
            default: begin lo = (a < b) ? b : a; hi = (a < b) ? a : b; end
        endcase
    endfunction

    // Value on or just beside a range edge, or inside it
    function automatic logic [31:0] pick_near(input logic [31:0] lo, input logic [31:0] hi);
        case ($urandom_range(0, 4))
            0:       return lo;
            1:       return hi;
            2:       return lo - 1;
            3:       return hi + 1;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    function automatic rule_beat_t make_random_beat();
        rule_beat_t  b;
        int unsigned idx;
        logic [31:0] lo;
        logic [31:0] hi;
        b.op       = ($urandom_range(0, 99) < ((rules_stored < RULES) ? 25 : 12)) ?
                     OP_ADD : OP_CHECK;
        // fields the command ignores still carry noise
        b.dir      = 1'($urandom_range(0, 1));
        b.proto    = 1'($urandom_range(0, 1));
        b.port_lo  = 16'($urandom);
        b.port_hi  = 16'($urandom);
        b.ip_lo    = $urandom;
        b.ip_hi    = $urandom;
        b.pkt_port = 16'($urandom);
        b.pkt_ip   = $urandom;
        if (b.op == OP_ADD)
        begin
            gen_range(32'h0000FFFF, lo, hi);
            b.port_lo = 16'(lo);
            b.port_hi = 16'(hi);
            gen_range(32'hFFFFFFFF, lo, hi);
            b.ip_lo = lo;
            b.ip_hi = hi;
        end
        else if (rules_stored != 0 && $urandom_range(0, 9) < 7)
        begin
            // aim the packet at a stored rule, sometimes on the wrong class
            idx        = $urandom_range(0, rules_stored - 1);
            b.dir      = stored_dir[idx] ^ ($urandom_range(0, 99) < 10);
            b.proto    = stored_proto[idx] ^ ($urandom_range(0, 99) < 10);
            b.pkt_port = 16'(pick_near(32'(stored_port_lo[idx]), 32'(stored_port_hi[idx])));
            b.pkt_ip   = pick_near(stored_ip_lo[idx], stored_ip_hi[idx]);
        end
        return b;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic send_beat(input rule_beat_t b, input logic typed, input verdict_t want);
        verdict_t v;
        int       gap;
        push           <= 1'b1;
        command        <= b.op;
        direction      <= b.dir;
        protocol       <= b.proto;
        rule_port_low  <= b.port_lo;
        rule_port_high <= b.port_hi;
        rule_ip_low    <= b.ip_lo;
        rule_ip_high   <= b.ip_hi;
        packet_port    <= b.pkt_port;
        packet_ip      <= b.pkt_ip;
        do
            @(posedge clk);
        while (full);
        v = classify_beat(b);
        if (typed)
            v = want;
        expected_verdicts.insert(expected_verdicts.size(), v);
        gap = steady_run ? 0 : pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop push and hold until every pending verdict has come back
    task automatic wait_for_drain();
        push <= 1'b0;
        do
            @(posedge clk);
        while (expected_verdicts.size() != 0);
    endtask

    task automatic check_result();
        verdict_t want;
        if (expected_verdicts.size() == 0)
        begin
            report_mismatch($sformatf("result beat with nothing pending: accepted=%0b table_full=%0b",
                                      accepted, table_full));
            return;
        end
        want = expected_verdicts.pop_front();
        if (accepted !== want.accepted)
            report_mismatch($sformatf("result %0d: accepted=%0b, want %0b",
                                      results_seen, accepted, want.accepted));
        if (table_full !== want.table_full)
            report_mismatch($sformatf("result %0d: table_full=%0b, want %0b",
                                      results_seen, table_full, want.table_full));
    endtask

    // Result side: random stalls plus one long hold-off to back the block up
    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            check_result();
            results_seen++;
        end
        if (!long_hold_done && results_seen == 150)
        begin
            hold_left      = 300;
            long_hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else
        begin
            pop <= 1'b1;
            hold_left = steady_run ? 0 : pick_gap();
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rule_beat_t b;
        rst_n          <= 1'b0;
        push           <= 1'b0;
        pop            <= 1'b0;
        command        <= OP_ADD;
        direction      <= 1'b0;
        protocol       <= 1'b0;
        rule_port_low  <= '0;
        rule_port_high <= '0;
        rule_ip_low    <= '0;
        rule_ip_high   <= '0;
        packet_port    <= '0;
        packet_ip      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
        wait_for_drain();

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == 350)
                wait_for_drain();
            steady_run = (n >= 500 && n < 560);
            b = make_random_beat();
            send_beat(b, 1'b0, '{1'b0, 1'b0});
        end
        steady_run = 1'b0;
        wait_for_drain();
        // catch any stray result beat after the last one expected
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
design/frm_pkg.sv
design/frm_front.sv
design/frm_back.sv
design/firewall_rule_match.sv
tb/firewall_rule_match_test.sv
